[hdl/nbm_pkg.sv]
`default_nettype none
package nbm_pkg;

    localparam logic [1:0] KIND_PRG    = 2'd0;
    localparam logic [1:0] KIND_CHR    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [1:0] CFG_MIRROR    = 2'd2;

    localparam int QDEPTH = 2;

    // one queued job: which mapping list to emit, the bank values it maps
    // and the status fields
    typedef struct packed {
        logic            do_prg;
        logic            do_chr;
        logic [7:0][7:0] banks;
        logic [1:0]      mirror;
        logic            irq_line;
        logic            irq_raised;
    } job_t;

endpackage
`default_nettype wire

[hdl/nbm_front.sv]
`default_nettype none
module nbm_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire logic [15:0]         address,
    input  wire logic [7:0]          data,
    input  wire logic [15:0]         cycles,
    input  wire logic                default_mirroring,
    input  wire logic                chr_present,
    output logic                     job_valid,
    input  wire logic                job_ready,
    output nbm_pkg::job_t            job
);
    import nbm_pkg::*;

    logic [7:0]  prg_reg [3];
    logic [7:0]  chr_reg [8];
    logic [7:0]  prg_new [3];
    logic [7:0]  chr_new [8];
    logic [15:0] reload_reg, count_reg, mask_reg;
    logic        on_reg, flag_reg, mset_reg;
    logic [1:0]  mmode_reg;

    logic [3:0]  blk;
    logic [1:0]  sub;
    logic [15:0] masked;
    logic        tick_go, fire;
    logic [2:0]  cidx;
    logic [3:0]  nib;

    function automatic logic [7:0] with_nibble(input logic [7:0] r, input logic hi,
                                               input logic [3:0] n);
        return hi ? {n, r[3:0]} : {r[7:4], n};
    endfunction

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign fire      = in_valid & job_ready;
    assign blk       = address[15:12];
    assign sub       = address[1:0];
    assign nib       = data[3:0];
    assign masked    = count_reg & mask_reg;
    assign tick_go   = on_reg && (cycles != 16'd0) && (masked != 16'd0);
    assign cidx      = {blk[1:0] - 2'd2, address[1]};

    // bank registers as they stand after this request
    always_comb
    begin
        prg_new = prg_reg;
        chr_new = chr_reg;
        if (!cmd)
        begin
            case (blk)
                4'h8: prg_new[address[1]] = with_nibble(prg_reg[address[1]], address[0], nib);
                4'h9:
                    if (!sub[1])
                        prg_new[2] = with_nibble(prg_reg[2], address[0], nib);
                4'hA, 4'hB, 4'hC, 4'hD:
                    chr_new[cidx] = with_nibble(chr_reg[cidx], address[0], nib);
                default: ;
            endcase
        end
    end

    // status reflects the state after this request is applied
    always_comb
    begin
        job = '0;
        job.mirror   = mset_reg ? mmode_reg : {1'b0, default_mirroring};
        job.irq_line = flag_reg;
        if (cmd)
        begin
            if (tick_go && cycles >= masked)
            begin
                job.irq_line   = 1'b1;
                job.irq_raised = 1'b1;
            end
        end
        else
        begin
            case (blk)
                4'h8: job.do_prg = 1'b1;
                4'h9: job.do_prg = ~sub[1];
                4'hA, 4'hB, 4'hC, 4'hD: job.do_chr = chr_present;
                4'hF:
                begin
                    if (sub == 2'd0 || sub == 2'd1)
                        job.irq_line = 1'b0;
                    if (sub == 2'd2)
                        job.mirror = data[1:0];
                end
                default: ;
            endcase
        end
        // hand the bank values to the back end so later writes cannot disturb them
        for (int i = 0; i < 8; i++)
            job.banks[i] = chr_new[i];
        if (job.do_prg)
            for (int i = 0; i < 3; i++)
                job.banks[i] = prg_new[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                prg_reg[i] <= 8'(i);
            for (int i = 0; i < 8; i++)
                chr_reg[i] <= 8'(i);
            reload_reg <= '0;
            count_reg  <= '0;
            mask_reg   <= 16'hFFFF;
            on_reg     <= 1'b0;
            flag_reg   <= 1'b0;
            mmode_reg  <= 2'd0;
            mset_reg   <= 1'b0;
        end
        else if (fire)
        begin
            prg_reg <= prg_new;
            chr_reg <= chr_new;
            if (cmd)
            begin
                if (tick_go)
                begin
                    if (cycles >= masked)
                    begin
                        count_reg <= count_reg - masked;
                        flag_reg  <= 1'b1;
                    end
                    else
                        count_reg <= count_reg - cycles;
                end
            end
            else
            begin
                case (blk)
                    4'hE:
                        case (sub)
                            2'd0: reload_reg[3:0]   <= nib;
                            2'd1: reload_reg[7:4]   <= nib;
                            2'd2: reload_reg[11:8]  <= nib;
                            default: reload_reg[15:12] <= nib;
                        endcase
                    4'hF:
                        case (sub)
                            2'd0:
                            begin
                                flag_reg  <= 1'b0;
                                count_reg <= reload_reg;
                            end
                            2'd1:
                            begin
                                flag_reg <= 1'b0;
                                on_reg   <= data[0];
                                if (data[3])
                                    mask_reg <= 16'h000F;
                                else if (data[2])
                                    mask_reg <= 16'h00FF;
                                else if (data[1])
                                    mask_reg <= 16'h0FFF;
                                else
                                    mask_reg <= 16'hFFFF;
                            end
                            2'd2:
                            begin
                                mmode_reg <= data[1:0];
                                mset_reg  <= 1'b1;
                            end
                            default: ;
                        endcase
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

[hdl/nbm_queue.sv]
`default_nettype none
module nbm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire nbm_pkg::job_t  wr_job,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output nbm_pkg::job_t       rd_job
);
    import nbm_pkg::*;

    job_t        slot_reg [QDEPTH];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign wr_ready = (cnt_reg != 2'(QDEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = slot_reg[rp_reg];
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

[hdl/nbm_back.sv]
`default_nettype none
module nbm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire nbm_pkg::job_t  job,
    input  wire logic [7:0]     prg_bank_count,
    input  wire logic [7:0]     chr_bank_count,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          kind,
    output logic [2:0]          window,
    output logic [7:0]          bank,
    output logic [1:0]          mirror,
    output logic                irq_line,
    output logic                irq_raised,
    output logic                last
);
    import nbm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOD  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t      state_reg;
    logic [3:0]  idx_reg;     // 0..7 mappings, 8 status
    logic [8:0]  rem_reg;
    logic [8:0]  div_reg;
    logic [2:0]  step_reg;
    logic        is_prg_reg;
    job_t        job_reg;
    logic [8:0]  pcnt;
    logic [8:0]  trial;
    logic        lastmap;

    assign pcnt = (prg_bank_count == 8'd0) ? 9'd256 : {1'b0, prg_bank_count};
    assign trial = rem_reg - (div_reg << step_reg);
    assign lastmap = is_prg_reg ? (idx_reg == 4'd3) : (idx_reg == 4'd7);
    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign mirror    = job_reg.mirror;
    assign irq_line  = job_reg.irq_line;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= 4'd0;
            rem_reg    <= 9'd0;
            div_reg    <= 9'd0;
            step_reg   <= 3'd0;
            is_prg_reg <= 1'b0;
            job_reg    <= '0;
            kind       <= KIND_STATUS;
            window     <= 3'd0;
            bank       <= 8'd0;
            irq_raised <= 1'b0;
            last       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        job_reg    <= job;
                        is_prg_reg <= job.do_prg;
                        idx_reg    <= 4'd0;
                        if (job.do_prg || job.do_chr)
                        begin
                            rem_reg  <= {1'b0, job.banks[0]};
                            div_reg  <= job.do_prg ? pcnt : {1'b0, chr_bank_count};
                            step_reg <= 3'd7;
                            state_reg <= S_MOD;
                        end
                        else
                        begin
                            kind       <= KIND_STATUS;
                            window     <= 3'd0;
                            bank       <= 8'd0;
                            irq_raised <= job.irq_raised;
                            last       <= 1'b1;
                            idx_reg    <= 4'd8;
                            state_reg  <= S_OUT;
                        end
                    end
                S_MOD:
                begin
                    // restoring remainder, one shift per cycle
                    if ({7'd0, rem_reg} >= ({7'd0, div_reg} << step_reg))
                        rem_reg <= trial;
                    if (step_reg == 3'd0)
                    begin
                        kind       <= is_prg_reg ? KIND_PRG : KIND_CHR;
                        window     <= idx_reg[2:0];
                        irq_raised <= 1'b0;
                        last       <= 1'b0;
                        if (is_prg_reg && idx_reg == 4'd3)
                            bank <= 8'(pcnt - 9'd1);
                        else if ({7'd0, rem_reg} >= {7'd0, div_reg})
                            bank <= trial[7:0];
                        else
                            bank <= rem_reg[7:0];
                        state_reg <= S_OUT;
                    end
                    else
                        step_reg <= step_reg - 3'd1;
                end
                S_OUT:
                    if (out_ready)
                    begin
                        if (idx_reg == 4'd8)
                            state_reg <= S_IDLE;
                        else if (lastmap)
                        begin
                            kind       <= KIND_STATUS;
                            window     <= 3'd0;
                            bank       <= 8'd0;
                            irq_raised <= job_reg.irq_raised;
                            last       <= 1'b1;
                            idx_reg    <= 4'd8;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 4'd1;
                            rem_reg   <= {1'b0, job_reg.banks[idx_reg[2:0] + 3'd1]};
                            step_reg  <= 3'd7;
                            state_reg <= S_MOD;
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/nibble_bank_mapper_with_irq_core.sv]
// A status-only item yields one status result. A PRG write yields its four mapping results
// and a CHR write its eight (none when no CHR banks are set), each followed by the status result.
// Each mapping result comes from an 8-step shift-subtract remainder plus output.
// A two-entry job queue parts front from back, so requests are taken while the back end
// is still busy with an earlier job, until the queue is full.
// Reset (rst_n, async low): bank registers to 0,1,2 and 0..7, counters and IRQ cleared.
`default_nettype none
module nibble_bank_mapper_with_irq_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  data,
    input  wire logic [15:0] cycles,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [2:0]       window,
    output logic [7:0]       bank,
    output logic [1:0]       mirror,
    output logic             irq_line,
    output logic             irq_raised,
    output logic             last
);
    import nbm_pkg::*;

    logic [7:0] prg_cnt_reg, chr_cnt_reg;
    logic       dmir_reg;
    logic       f_valid, f_ready, b_valid, b_ready;
    job_t       f_job, b_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_cnt_reg <= 8'd2;
            chr_cnt_reg <= 8'd0;
            dmir_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRG_COUNT: prg_cnt_reg <= cfg_data;
                CFG_CHR_COUNT: chr_cnt_reg <= cfg_data;
                CFG_MIRROR:    dmir_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    nbm_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .cmd, .address, .data, .cycles,
        .default_mirroring(dmir_reg),
        .chr_present(chr_cnt_reg != 8'd0),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    nbm_queue u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
    );

    nbm_back u_back (
        .clk, .rst_n,
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .prg_bank_count(prg_cnt_reg), .chr_bank_count(chr_cnt_reg),
        .out_valid, .out_ready, .kind, .window, .bank, .mirror,
        .irq_line, .irq_raised, .last
    );

    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind == KIND_STATUS)
        else $error("last result not status");
    a_raise_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_raised |-> irq_line)
        else $error("raised without pending");
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |-> bank == 8'd0 && window == 3'd0)
        else $error("status carries bank");

endmodule
`default_nettype wire

[tb/nibble_bank_mapper_with_irq_core_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module nibble_bank_mapper_with_irq_core_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        cmd,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  data,
    input  wire logic [15:0] cycles,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [2:0]  window,
    input  wire logic [7:0]  bank,
    input  wire logic [1:0]  mirror,
    input  wire logic        irq_line,
    input  wire logic        irq_raised,
    input  wire logic        last,
    output int               fail_count,
    output int               pending_count
);
    import nbm_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] window;
        logic [7:0] bank;
        logic [1:0] mirror;
        logic       irq_line;
        logic       irq_raised;
        logic       last;
    } mapping_t;

    mapping_t expected_maps[$];

    logic [7:0]  prg_total, chr_total;
    logic        mirror_default;
    logic [7:0]  prg_bank[3];
    logic [7:0]  chr_bank[8];
    logic [15:0] irq_reload, irq_count, width_mask;
    logic        irq_on, irq_flag, mirror_set;
    logic [1:0]  mirror_mode;

    function automatic logic [7:0] with_nibble(logic [7:0] r, logic hi, logic [7:0] d);
        return hi ? {d[3:0], r[3:0]} : {r[7:4], d[3:0]};
    endfunction

    function automatic logic [1:0] cur_mirror();
        return mirror_set ? mirror_mode : {1'b0, mirror_default};
    endfunction

    task automatic push_map(logic [1:0] k, logic [2:0] w, logic [7:0] b, logic r, logic l);
        mapping_t m;
        m.kind = k;
        m.window = w;
        m.bank = b;
        m.mirror = cur_mirror();
        m.irq_line = irq_flag;
        m.irq_raised = r;
        m.last = l;
        expected_maps.push_back(m);
    endtask

    task automatic push_prg();
        int cnt;
        cnt = (prg_total == 0) ? 256 : prg_total;
        for (int i = 0; i < 3; i++)
            push_map(KIND_PRG, 3'(i), 8'(prg_bank[i] % cnt), 1'b0, 1'b0);
        push_map(KIND_PRG, 3'd3, 8'(cnt - 1), 1'b0, 1'b0);
    endtask

    task automatic push_chr();
        if (chr_total != 0)
            for (int i = 0; i < 8; i++)
                push_map(KIND_CHR, 3'(i), 8'(chr_bank[i] % chr_total), 1'b0, 1'b0);
    endtask

    task automatic predict_request();
        logic        raised;
        logic [15:0] masked;
        logic [3:0]  blk;
        logic [1:0]  sub;
        int          idx;
        raised = 1'b0;
        blk = address[15:12];
        sub = address[1:0];
        if (cmd) begin
            masked = irq_count & width_mask;
            if (irq_on && cycles != 0 && masked != 0) begin
                if (cycles >= masked) begin
                    irq_count = irq_count - masked;
                    irq_flag = 1'b1;
                    raised = 1'b1;
                end
                else
                    irq_count = irq_count - cycles;
            end
        end
        else if (blk == 4'h8) begin
            prg_bank[address[1]] = with_nibble(prg_bank[address[1]], address[0], data);
            push_prg();
        end
        else if (blk == 4'h9) begin
            if (sub <= 1) begin
                prg_bank[2] = with_nibble(prg_bank[2], address[0], data);
                push_prg();
            end
        end
        else if (blk >= 4'hA && blk <= 4'hD) begin
            idx = ((blk - 4'hA) << 1) | address[1];
            chr_bank[idx] = with_nibble(chr_bank[idx], address[0], data);
            push_chr();
        end
        else if (blk == 4'hE)
            irq_reload[sub*4 +: 4] = data[3:0];
        else if (blk == 4'hF) begin
            if (sub == 0) begin
                irq_flag = 1'b0;
                irq_count = irq_reload;
            end
            else if (sub == 1) begin
                irq_flag = 1'b0;
                width_mask = data[3] ? 16'h000F : data[2] ? 16'h00FF :
                             data[1] ? 16'h0FFF : 16'hFFFF;
                irq_on = data[0];
            end
            else if (sub == 2) begin
                mirror_mode = data[1:0];
                mirror_set = 1'b1;
            end
        end
        push_map(KIND_STATUS, 3'd0, 8'd0, raised, 1'b1);
    endtask

    task automatic compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        mapping_t e;
        if (!rst_n) begin
            fail_count = 0;
            expected_maps.delete();
            prg_total = 8'd2;
            chr_total = 8'd0;
            mirror_default = 1'b0;
            for (int i = 0; i < 3; i++)
                prg_bank[i] = 8'(i);
            for (int i = 0; i < 8; i++)
                chr_bank[i] = 8'(i);
            irq_reload = '0;
            irq_count = '0;
            width_mask = 16'hFFFF;
            irq_on = 1'b0;
            irq_flag = 1'b0;
            mirror_mode = 2'd0;
            mirror_set = 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PRG_COUNT: prg_total = cfg_data;
                    CFG_CHR_COUNT: chr_total = cfg_data;
                    CFG_MIRROR:    mirror_default = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (expected_maps.size() == 0) begin
                    $error("unexpected result: kind %0d window %0d bank %0d", kind, window, bank);
                    fail_count++;
                end
                else begin
                    e = expected_maps.pop_front();
                    compare_field("kind", e.kind, kind);
                    compare_field("window", e.window, window);
                    compare_field("bank", e.bank, bank);
                    compare_field("mirror", e.mirror, mirror);
                    compare_field("irq_line", e.irq_line, irq_line);
                    compare_field("irq_raised", e.irq_raised, irq_raised);
                    compare_field("last", e.last, last);
                end
            end
            if (in_valid && in_ready)
                predict_request();
        end
        pending_count = expected_maps.size();
    end

endmodule
`default_nettype wire

[tb/nibble_bank_mapper_with_irq_core_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module nibble_bank_mapper_with_irq_core_test;
    import nbm_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic [15:0] address = 16'h8000;
    logic [7:0]  data = '0;
    logic [15:0] cycles = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [2:0]  window;
    logic [7:0]  bank;
    logic [1:0]  mirror;
    logic        irq_line, irq_raised, last;
    int          fail_count, pending_count;
    int          idle_cycles = 0;
    bit          long_hold = 1'b0;
    bit          hold_done = 1'b0;

    always #10 clk = ~clk;

    nibble_bank_mapper_with_irq_core dut (.*);

    nibble_bank_mapper_with_irq_core_checker checker_inst (.*);

    // receiver: own stall pattern, plus one long hold-off while input keeps coming
    always @(posedge clk)
    begin
        int phase;
        phase = $urandom_range(0, 99);
        if (long_hold)
            out_ready <= 1'b0;
        else if (phase < 40)
            out_ready <= 1'b1;
        else
            out_ready <= $urandom_range(0, 3) != 0;
    end

    initial
    begin
        wait (rst_n);
        repeat (60) @(posedge clk);
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        hold_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("nibble_bank_mapper_with_irq_core_test: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(logic c, logic [15:0] a, logic [7:0] d, logic [15:0] cy);
        in_valid <= 1'b1;
        cmd <= c;
        address <= a;
        data <= d;
        cycles <= cy;
        do @(posedge clk); while (!in_ready);
    endtask

    // burst of back-to-back requests, then, two times in three, drop valid for a random gap
    int burst_left = 0;
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [15:0] mapper_addr(logic [3:0] blk);
        logic [15:0] a;
        a = 16'($urandom());
        a[15:12] = blk;
        return a;
    endfunction

    task automatic random_request();
        int pick;
        logic [15:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_request(1'b1, 16'($urandom()), 8'($urandom()),
                         ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40)));
        else if (pick < 45)
            send_request(1'b0, mapper_addr(4'($urandom_range(8, 9))), 8'($urandom()), 16'($urandom()));
        else if (pick < 57)
            send_request(1'b0, mapper_addr(4'($urandom_range(10, 13))), 8'($urandom()),
                         16'($urandom()));
        else if (pick < 67)
            send_request(1'b0, mapper_addr(4'hE), 8'($urandom()), 16'($urandom()));
        else if (pick < 92) begin
            a = mapper_addr(4'hF);
            a[1:0] = 2'($urandom_range(0, 2));
            // set the enable bit so the counter runs and raises happen often
            if (a[1:0] == 2'd1)
                send_request(1'b0, a, {4'($urandom()), 4'($urandom_range(0, 15)) | 4'd1},
                             16'($urandom()));
            else
                send_request(1'b0, a, 8'($urandom()), 16'($urandom()));
        end
        else
            send_request(1'b0, 16'($urandom()), 8'($urandom()), 16'($urandom()));
    endtask

    initial
    begin
        logic [7:0] prg_settings[4] = '{8'd2, 8'd254, 8'd0, 8'd5};
        logic [7:0] chr_settings[4] = '{8'd0, 8'd248, 8'd3, 8'd1};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, writes to PRG, CHR, reload and control registers, extremes
        send_request(1'b0, 16'h8000, 8'hFF, 16'hFFFF);
        send_request(1'b0, 16'h8001, 8'hF0, 16'h0000);
        send_request(1'b0, 16'h8003, 8'h0F, 16'h0000);
        send_request(1'b0, 16'h9001, 8'hFF, 16'h0000);
        send_request(1'b0, 16'h9002, 8'h55, 16'h0000);
        send_request(1'b0, 16'hF003, 8'hFF, 16'h0000);
        send_request(1'b0, 16'h7FFF, 8'hFF, 16'h0000);
        send_request(1'b0, 16'hA000, 8'h0C, 16'h0000);
        send_request(1'b0, 16'hE000, 8'h03, 16'h0000);
        send_request(1'b0, 16'hE001, 8'h00, 16'h0000);
        send_request(1'b0, 16'hF000, 8'h00, 16'h0000);
        send_request(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_request(1'b0, 16'hF001, 8'h01, 16'h0000);
        send_request(1'b1, 16'h0000, 8'h00, 16'h0000);
        send_request(1'b1, 16'h0000, 8'h00, 16'h0001);
        send_request(1'b1, 16'h0000, 8'h00, 16'hFFFF);
        send_request(1'b1, 16'h0000, 8'h00, 16'h0005);
        send_request(1'b0, 16'hF001, 8'h0F, 16'h0000);
        send_request(1'b0, 16'hF001, 8'h05, 16'h0000);
        send_request(1'b0, 16'hF001, 8'h03, 16'h0000);
        send_request(1'b0, 16'hF002, 8'h03, 16'h0000);
        send_request(1'b0, 16'hF002, 8'hFE, 16'h0000);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_PRG_COUNT, prg_settings[ph]);
            write_reg(CFG_CHR_COUNT, chr_settings[ph]);
            write_reg(CFG_MIRROR, 8'(ph[0]) | 8'($urandom()) & 8'hFE);
            if (ph == 1)
                send_request(1'b0, 16'hDFFF, 8'hFF, 16'h0000);
            for (int n = 0; n < 85 || (ph == 0 && !hold_done); n++) begin
                pace();
                random_request();
            end
            drain();
        end

        if (fail_count == 0)
            $display("nibble_bank_mapper_with_irq_core_test: PASS");
        else
            $display("nibble_bank_mapper_with_irq_core_test: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

[nibble_bank_mapper_with_irq_core.f]
hdl/nbm_pkg.sv
hdl/nbm_front.sv
hdl/nbm_queue.sv
hdl/nbm_back.sv
hdl/nibble_bank_mapper_with_irq_core.sv
tb/nibble_bank_mapper_with_irq_core_checker.sv
tb/nibble_bank_mapper_with_irq_core_test.sv
